### design/cte_pkg.sv
package cte_pkg;

   // field and result widths
   localparam int unsigned DayW    = 5;
   localparam int unsigned MonthW  = 4;
   localparam int unsigned YearW   = 14;
   localparam int unsigned HourW   = 5;
   localparam int unsigned MinuteW = 6;
   localparam int unsigned SecondW = 6;
   localparam int unsigned EpochW  = 38;
   localparam int unsigned StatusW = 2;

   // internal widths: day count, seconds within a day, full unsaturated total
   localparam int unsigned DaysW  = 23;
   localparam int unsigned TodW   = 17;
   localparam int unsigned TotalW = 40;
   localparam int unsigned LeapW  = 13;

   // calendar constants
   localparam logic [YearW-1:0]  EpochYear        = YearW'(1970);
   localparam logic [8:0]        DaysPerYear      = 9'd365;
   localparam logic [TodW-1:0]   SecsPerDay       = TodW'(86400);
   localparam logic [11:0]       SecsPerHour      = 12'd3600;
   localparam logic [5:0]        SecsPerMinute    = 6'd60;
   localparam logic [LeapW-1:0]  LeapsBeforeEpoch = LeapW'(477);

   // floor(n / 100) = (n * Recip100) >> Recip100Shift, exact for 14-bit n
   localparam logic [12:0]       Recip100         = 13'd5243;
   localparam int unsigned       Recip100Shift    = 19;
   localparam int unsigned       RecipProdW       = YearW + 13;
   localparam int unsigned       Q100W            = RecipProdW - Recip100Shift;

   // status codes
   localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
   localparam logic [StatusW-1:0] STATUS_EARLY    = 2'd1;
   localparam logic [StatusW-1:0] STATUS_BAD_DATE = 2'd2;

   // month numbers
   localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
   localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
   localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [DayW-1:0]    day_of_month;
      logic [MonthW-1:0]  month;
      logic [YearW-1:0]   year;
      logic [HourW-1:0]   hour;
      logic [MinuteW-1:0] minute;
      logic [SecondW-1:0] second;
   } req_type;

   typedef struct packed {
      logic [EpochW-1:0]  epoch_seconds;
      logic [StatusW-1:0] status;
   } rsp_type;

   // day count stage result
   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [DaysW-1:0]   days;
      logic [TodW-1:0]    tod;
   } day_count_type;

   // days in all months before the given month, non-leap year
   function automatic logic [8:0] days_before(input logic [MonthW-1:0] month);
      logic [8:0] result;
      unique case (month)
         4'd1:    result = 9'd0;
         4'd2:    result = 9'd31;
         4'd3:    result = 9'd59;
         4'd4:    result = 9'd90;
         4'd5:    result = 9'd120;
         4'd6:    result = 9'd151;
         4'd7:    result = 9'd181;
         4'd8:    result = 9'd212;
         4'd9:    result = 9'd243;
         4'd10:   result = 9'd273;
         4'd11:   result = 9'd304;
         4'd12:   result = 9'd334;
         default: result = 9'd0;
      endcase
      return result;
   endfunction

endpackage

### design/cte_days.sv
module cte_days (
   input  cte_pkg::req_type       req,
   output cte_pkg::day_count_type count
);

   logic [cte_pkg::YearW-1:0]      year_m1;
   logic [cte_pkg::YearW-1:0]      years;
   logic [cte_pkg::RecipProdW-1:0] prod_m1;
   logic [cte_pkg::RecipProdW-1:0] prod_y;
   logic [cte_pkg::Q100W-1:0]      q100_m1;
   logic [cte_pkg::Q100W-1:0]      q100_y;
   logic                           div4;
   logic                           div100;
   logic                           div400;
   logic                           leap_now;
   logic [cte_pkg::LeapW-1:0]      leaps;
   logic [cte_pkg::DaysW-1:0]      year_days;
   logic [cte_pkg::DaysW-1:0]      days;
   logic [cte_pkg::TodW-1:0]       tod;
   logic                           bad_date;

   // hundreds of year-1 and of year by reciprocal multiply
   assign year_m1 = req.year - cte_pkg::YearW'(1);
   assign prod_m1 = cte_pkg::RecipProdW'(year_m1) * cte_pkg::RecipProdW'(cte_pkg::Recip100);
   assign prod_y  = cte_pkg::RecipProdW'(req.year) * cte_pkg::RecipProdW'(cte_pkg::Recip100);
   assign q100_m1 = prod_m1[cte_pkg::RecipProdW-1:cte_pkg::Recip100Shift];
   assign q100_y  = prod_y[cte_pkg::RecipProdW-1:cte_pkg::Recip100Shift];

   // year divides by 100 (or 400) exactly when its quotient steps past year-1's
   assign div4     = (req.year[1:0] == 2'b00);
   assign div100   = (q100_y != q100_m1);
   assign div400   = (q100_y[cte_pkg::Q100W-1:2] != q100_m1[cte_pkg::Q100W-1:2]);
   assign leap_now = (div4 && !div100) || div400;

   // leap days in epoch year through year-1
   assign leaps = cte_pkg::LeapW'(year_m1[cte_pkg::YearW-1:2])
                - cte_pkg::LeapW'(q100_m1)
                + cte_pkg::LeapW'(q100_m1[cte_pkg::Q100W-1:2])
                - cte_pkg::LeapsBeforeEpoch;

   // whole years, months and days
   assign years     = req.year - cte_pkg::EpochYear;
   assign year_days = cte_pkg::DaysW'(years) * cte_pkg::DaysW'(cte_pkg::DaysPerYear);
   assign days = year_days
               + cte_pkg::DaysW'(leaps)
               + cte_pkg::DaysW'(cte_pkg::days_before(req.month))
               + cte_pkg::DaysW'(leap_now && (req.month > cte_pkg::MONTH_FEB))
               + cte_pkg::DaysW'(req.day_of_month)
               - cte_pkg::DaysW'(1);

   // seconds within the day, out-of-range fields add in full
   assign tod = cte_pkg::TodW'(req.hour) * cte_pkg::TodW'(cte_pkg::SecsPerHour)
              + cte_pkg::TodW'(req.minute) * cte_pkg::TodW'(cte_pkg::SecsPerMinute)
              + cte_pkg::TodW'(req.second);

   // status, early year checked first
   assign bad_date = (req.month < cte_pkg::MONTH_JAN) || (req.month > cte_pkg::MONTH_DEC)
                  || (req.day_of_month == '0);

   always_comb begin
      count.days = days;
      count.tod  = tod;
      priority if (req.year < cte_pkg::EpochYear) begin
         count.status = cte_pkg::STATUS_EARLY;
      end else if (bad_date) begin
         count.status = cte_pkg::STATUS_BAD_DATE;
      end else begin
         count.status = cte_pkg::STATUS_OK;
      end
   end

endmodule

### design/calendar_to_epoch_seconds_core.sv
// Converts a Gregorian calendar date and time of day into seconds since
// 1970-01-01 00:00:00, with no time zone and no leap-second table. Takes one
// request per clock cycle while rsp_ready does not stall the result. The
// request register captures it at acceptance, the day count register (year,
// leap and month arithmetic) loads from it and the result register (days
// times 86400 plus time of day, saturated to 38 bits) loads from that in
// turn. A year before 1970 returns status 1, a month outside 1..12 or a day
// of 0 returns status 2, both with zero seconds. Days past the end of a month
// and out-of-range time fields are not flagged and simply add in.
module calendar_to_epoch_seconds_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cte_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cte_pkg::rsp_type rsp_payload
);

   cte_pkg::req_type        req_ff;
   logic                    req_valid_ff;
   logic                    req_valid_in;
   cte_pkg::day_count_type  count_in;
   cte_pkg::day_count_type  count_ff;
   logic                    count_valid_ff;
   logic                    count_valid_in;
   cte_pkg::rsp_type        rsp_in;
   cte_pkg::rsp_type        rsp_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    req_accept;
   logic                    count_load;
   logic                    rsp_load;
   logic [cte_pkg::TotalW-1:0] total;

   // pipeline flow control
   assign rsp_load   = count_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign count_load = req_valid_ff && (!count_valid_ff || rsp_load);
   assign req_ready  = !req_valid_ff || count_load;
   assign req_accept = req_valid && req_ready;

   assign req_valid_in   = req_accept || (req_valid_ff && !count_load);
   assign count_valid_in = count_load || (count_valid_ff && !rsp_load);
   assign rsp_valid_in   = rsp_load || (rsp_valid_ff && !rsp_ready);

   // day count from the registered request
   cte_days u_days (
      .req   (req_ff),
      .count (count_in)
   );

   // seconds total and saturation
   assign total = cte_pkg::TotalW'(count_ff.days) * cte_pkg::TotalW'(cte_pkg::SecsPerDay)
                + cte_pkg::TotalW'(count_ff.tod);

   always_comb begin
      rsp_in.status = count_ff.status;
      priority if (count_ff.status != cte_pkg::STATUS_OK) begin
         rsp_in.epoch_seconds = '0;
      end else if (total[cte_pkg::TotalW-1:cte_pkg::EpochW] != '0) begin
         rsp_in.epoch_seconds = '1;
      end else begin
         rsp_in.epoch_seconds = total[cte_pkg::EpochW-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         count_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         req_valid_ff   <= req_valid_in;
         count_valid_ff <= count_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_payload;
      end
      if (count_load) begin
         count_ff <= count_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### tb/testbench.sv
module testbench;

   localparam int unsigned ClockPeriod  = 8;
   localparam int unsigned DrainCycles  = 12;
   localparam int unsigned TimeoutCycles = 250000;
   localparam int unsigned ReportLimit  = 10;
   localparam longint unsigned EpochMax = (64'd1 << cte_pkg::EpochW) - 64'd1;

   // days before each month in a common year, indexed by month - 1
   localparam int unsigned MonthStartDay [0:11] = '{
      0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
   };

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   cte_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   cte_pkg::rsp_type rsp_payload;

   // results predicted for accepted requests, oldest first
   cte_pkg::rsp_type pending_epochs[$];

   int unsigned req_idle_pct = 37;
   int unsigned rsp_idle_pct = 37;
   int unsigned hold_request = 0;
   int unsigned hold_left    = 0;
   int unsigned held_cycles  = 0;
   int unsigned requests_sent   = 0;
   int unsigned results_checked = 0;
   int unsigned error_count     = 0;
   int unsigned saturated_seen  = 0;
   int unsigned status_seen [0:3] = '{0, 0, 0, 0};

   calendar_to_epoch_seconds_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   initial begin
      #(TimeoutCycles * ClockPeriod);
      $display("timeout with %0d results still pending", pending_epochs.size());
      $display("testbench NOT OK");
      $finish;
   end

   // gregorian leap years in 1..n
   function automatic longint unsigned leap_years_through(input longint unsigned n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   // expected result for one calendar time
   function automatic cte_pkg::rsp_type predict_epoch(input cte_pkg::req_type item);
      cte_pkg::rsp_type res;
      longint unsigned  yr;
      longint unsigned  days;
      longint unsigned  total;
      res = '0;
      yr  = item.year;
      if (item.year < cte_pkg::EpochYear) begin
         res.status = cte_pkg::STATUS_EARLY;
      end else if (item.month < cte_pkg::MONTH_JAN || item.month > cte_pkg::MONTH_DEC ||
                   item.day_of_month == '0) begin
         res.status = cte_pkg::STATUS_BAD_DATE;
      end else begin
         days = (yr - 1970) * 365 + leap_years_through(yr - 1) - leap_years_through(1969);
         days += MonthStartDay[item.month - 1];
         // leap day of the current year counts once february is over
         if (item.month > cte_pkg::MONTH_FEB &&
             ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0))
            days += 1;
         days += longint'(item.day_of_month) - 1;
         total = days * 86400 + longint'(item.hour) * 3600 +
                 longint'(item.minute) * 60 + longint'(item.second);
         if (total > EpochMax)
            total = EpochMax;
         res.epoch_seconds = total[cte_pkg::EpochW-1:0];
         res.status        = cte_pkg::STATUS_OK;
      end
      return res;
   endfunction

   function automatic cte_pkg::req_type make_request(input int unsigned year,
                                                     input int unsigned month,
                                                     input int unsigned day,
                                                     input int unsigned hour,
                                                     input int unsigned minute,
                                                     input int unsigned second);
      cte_pkg::req_type item;
      item.day_of_month = cte_pkg::DayW'(day);
      item.month        = cte_pkg::MonthW'(month);
      item.year         = cte_pkg::YearW'(year);
      item.hour         = cte_pkg::HourW'(hour);
      item.minute       = cte_pkg::MinuteW'(minute);
      item.second       = cte_pkg::SecondW'(second);
      return item;
   endfunction

   // mostly well-formed times, with some raw bit noise
   function automatic cte_pkg::req_type random_calendar_time();
      cte_pkg::req_type item;
      int unsigned      pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         item.day_of_month = cte_pkg::DayW'($urandom);
         item.month        = cte_pkg::MonthW'($urandom);
         item.year         = cte_pkg::YearW'($urandom);
         item.hour         = cte_pkg::HourW'($urandom);
         item.minute       = cte_pkg::MinuteW'($urandom);
         item.second       = cte_pkg::SecondW'($urandom);
      end else begin
         item.day_of_month = cte_pkg::DayW'($urandom_range(31, 1));
         item.month        = cte_pkg::MonthW'($urandom_range(12, 1));
         item.hour         = cte_pkg::HourW'($urandom_range(23, 0));
         item.minute       = cte_pkg::MinuteW'($urandom_range(59, 0));
         item.second       = cte_pkg::SecondW'($urandom_range(60, 0));
         if (pick < 55)
            item.year = cte_pkg::YearW'($urandom_range(2100, 1970));
         else if (pick < 85)
            item.year = cte_pkg::YearW'($urandom_range(9999, 1970));
         else if (pick < 93)
            item.year = cte_pkg::YearW'($urandom_range(16383, 9999));
         else
            item.year = cte_pkg::YearW'($urandom_range(1969, 0));
         // out-of-range time of day now and then
         if ($urandom_range(99) < 5) begin
            item.hour   = cte_pkg::HourW'($urandom);
            item.minute = cte_pkg::MinuteW'($urandom);
            item.second = cte_pkg::SecondW'($urandom);
         end
      end
      return item;
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= ReportLimit)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // send one request, with random idle cycles ahead of it
   task automatic send_request(input cte_pkg::req_type item);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // drop valid and let every pending result come back
   task automatic finish_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_epochs.size() != 0)
         @(posedge clock);
   endtask

   // receiver: random stalls, plus long hold-offs on demand
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
            held_cycles++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // result checking and expectation capture
   always @(posedge clock) begin : check_results
      cte_pkg::rsp_type want;
      cte_pkg::rsp_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (pending_epochs.size() == 0) begin
               note_error($sformatf("result with nothing pending: seconds %0d status %0d",
                                    got.epoch_seconds, got.status));
            end else begin
               want = pending_epochs.pop_front();
               results_checked++;
               if (got.epoch_seconds !== want.epoch_seconds || got.status !== want.status)
                  note_error($sformatf(
                     "seconds expected %0d got %0d, status expected %0d got %0d",
                     want.epoch_seconds, got.epoch_seconds, want.status, got.status));
            end
         end
         if (req_valid && req_ready) begin
            want = predict_epoch(req_payload);
            pending_epochs.push_back(want);
            status_seen[want.status]++;
            if (want.epoch_seconds == cte_pkg::EpochW'(EpochMax))
               saturated_seen++;
         end
      end
   end

   // boundaries and each special case
   task automatic test_directed_cases();
      cte_pkg::req_type cases[$];
      cases.push_back(make_request(1970, cte_pkg::MONTH_JAN, 1, 0, 0, 0));
      cases.push_back(make_request(1969, cte_pkg::MONTH_DEC, 31, 23, 59, 59));
      cases.push_back(make_request(0, 0, 0, 0, 0, 0));
      cases.push_back(make_request(1969, 15, 0, 31, 63, 63));
      cases.push_back(make_request(2000, 0, 1, 0, 0, 0));
      cases.push_back(make_request(2000, 13, 1, 12, 0, 0));
      cases.push_back(make_request(2000, 15, 31, 0, 0, 0));
      cases.push_back(make_request(2000, 6, 0, 0, 0, 0));
      cases.push_back(make_request(2000, cte_pkg::MONTH_FEB, 29, 12, 30, 30));
      cases.push_back(make_request(2000, 3, 1, 0, 0, 0));
      cases.push_back(make_request(2100, 3, 1, 0, 0, 0));
      cases.push_back(make_request(2400, 3, 1, 0, 0, 0));
      cases.push_back(make_request(2023, cte_pkg::MONTH_FEB, 31, 0, 0, 0));
      cases.push_back(make_request(2024, cte_pkg::MONTH_DEC, 31, 23, 59, 60));
      cases.push_back(make_request(2038, cte_pkg::MONTH_JAN, 19, 3, 14, 8));
      cases.push_back(make_request(1999, cte_pkg::MONTH_DEC, 31, 31, 63, 63));
      cases.push_back(make_request(9999, cte_pkg::MONTH_DEC, 31, 23, 59, 59));
      cases.push_back(make_request(10680, cte_pkg::MONTH_DEC, 31, 23, 59, 59));
      cases.push_back(make_request(10681, cte_pkg::MONTH_JAN, 1, 0, 0, 0));
      cases.push_back(make_request(16383, cte_pkg::MONTH_DEC, 31, 31, 63, 63));
      cases.push_back(make_request(16383, 15, 31, 31, 63, 63));
      cases.push_back(make_request(1970, cte_pkg::MONTH_JAN, 31, 0, 0, 0));
      cases.push_back(make_request(8192, 8, 16, 16, 32, 32));
      foreach (cases[i])
         send_request(cases[i]);
      finish_phase();
   endtask

   // random mix with random idling on both sides
   task automatic test_random_mix();
      req_idle_pct = 37;
      rsp_idle_pct = 37;
      repeat (1450)
         send_request(random_calendar_time());
      finish_phase();
   endtask

   // full rate, no idling anywhere
   task automatic test_back_to_back();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (250)
         send_request(random_calendar_time());
      finish_phase();
      req_idle_pct = 37;
      rsp_idle_pct = 37;
   endtask

   // receiver holds off long enough for the pipeline to fill and stall requests
   task automatic test_receiver_hold_off();
      req_idle_pct = 0;
      hold_request = 300;
      repeat (150)
         send_request(random_calendar_time());
      finish_phase();
      req_idle_pct = 37;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_mix();
      test_back_to_back();
      test_receiver_hold_off();
      finish_phase();
      repeat (DrainCycles) @(posedge clock);
      if (pending_epochs.size() != 0)
         note_error($sformatf("%0d results never arrived", pending_epochs.size()));
      $display("covered %0d requests, %0d results checked: %0d ok (%0d saturated),",
               requests_sent, results_checked, status_seen[cte_pkg::STATUS_OK],
               saturated_seen);
      $display("%0d early year, %0d bad date; receiver held off %0d cycles, %0d errors found",
               status_seen[cte_pkg::STATUS_EARLY], status_seen[cte_pkg::STATUS_BAD_DATE],
               held_cycles, error_count);
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

### calendar_to_epoch_seconds_core.f
design/cte_pkg.sv
design/cte_days.sv
design/calendar_to_epoch_seconds_core.sv
tb/testbench.sv
